FILE: hdl/http_request_header_tokenizer_defines.svh
// ----------------------------------------------------------------------------
// HTTP request header tokenizer assertion macros
// Shared property forms for the assertion checker of the tokenizer.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEADER_TOKENIZER_DEFINES_SVH
`define HTTP_REQUEST_HEADER_TOKENIZER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HTOK_ASSERT_SAME(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("Assertion failed in the tokenizer checker.");

// The consequent must hold in the cycle after the antecedent.
`define HTOK_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("Assertion failed in the tokenizer checker.");

`endif

FILE: hdl/htok_pkg.sv
// ----------------------------------------------------------------------------
// Tokenizer package
// Widths, character codes, parse phases, token kinds and result types.
// ----------------------------------------------------------------------------
package htok_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned KindW   = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PhaseW  = 4;
  localparam int unsigned NumW    = 2;

  localparam logic [ByteW-1:0] CharNul   = 8'h00;
  localparam logic [ByteW-1:0] CharSp    = 8'h20;
  localparam logic [ByteW-1:0] CharColon = 8'h3A;
  localparam logic [ByteW-1:0] CharCr    = 8'h0D;
  localparam logic [ByteW-1:0] CharLf    = 8'h0A;

  localparam logic [PhaseW-1:0] PhMethod  = 4'd0;
  localparam logic [PhaseW-1:0] PhUrl     = 4'd1;
  localparam logic [PhaseW-1:0] PhVersion = 4'd2;
  localparam logic [PhaseW-1:0] PhLine    = 4'd3;
  localparam logic [PhaseW-1:0] PhKey     = 4'd4;
  localparam logic [PhaseW-1:0] PhSkip    = 4'd5;
  localparam logic [PhaseW-1:0] PhValue   = 4'd6;
  localparam logic [PhaseW-1:0] PhDone    = 4'd7;
  localparam logic [PhaseW-1:0] PhError   = 4'd8;

  localparam logic [KindW-1:0] KindNone    = 3'd0;
  localparam logic [KindW-1:0] KindMethod  = 3'd1;
  localparam logic [KindW-1:0] KindUrl     = 3'd2;
  localparam logic [KindW-1:0] KindVersion = 3'd3;
  localparam logic [KindW-1:0] KindKey     = 3'd4;
  localparam logic [KindW-1:0] KindValue   = 3'd5;

  localparam logic [StatusW-1:0] StatRunning  = 2'd0;
  localparam logic [StatusW-1:0] StatComplete = 2'd1;
  localparam logic [StatusW-1:0] StatError    = 2'd2;

  localparam logic [NumW-1:0] NumZero = 2'd0;
  localparam logic [NumW-1:0] NumOne  = 2'd1;
  localparam logic [NumW-1:0] NumTwo  = 2'd2;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [ByteW-1:0]   tbyte;
    logic               cvalid;
    logic               done;
    logic [StatusW-1:0] status;
    logic               last;
  } htok_res_t;

  typedef struct packed {
    logic [NumW-1:0]   num;
    htok_res_t         res0;
    htok_res_t         res1;
    logic [PhaseW-1:0] phase;
    logic              cr;
  } htok_step_t;

  function automatic logic [KindW-1:0] phase_kind(input logic [PhaseW-1:0] ph);
    logic [KindW-1:0] k;
    case (ph)
      PhMethod:        k = KindMethod;
      PhUrl:           k = KindUrl;
      PhVersion:       k = KindVersion;
      PhKey:           k = KindKey;
      PhSkip, PhValue: k = KindValue;
      default:         k = KindNone;
    endcase
    return k;
  endfunction

  function automatic htok_res_t mk_res(input logic [KindW-1:0] kind,
                                       input logic [ByteW-1:0] b,
                                       input logic cvalid,
                                       input logic done,
                                       input logic [StatusW-1:0] status);
    htok_res_t r;
    r.kind   = kind;
    r.tbyte  = cvalid ? b : CharNul;
    r.cvalid = cvalid;
    r.done   = done;
    r.status = status;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

FILE: hdl/htok_if.sv
// ----------------------------------------------------------------------------
// Tokenizer channels
// Valid/ready channels for request bytes and for token results.
// ----------------------------------------------------------------------------
interface htok_in_if import htok_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             message_start;

  modport source (output valid, output data_byte, output message_start, input ready);
  modport sink   (input valid, input data_byte, input message_start, output ready);
endinterface

interface htok_out_if import htok_pkg::*;;
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   token_kind;
  logic [ByteW-1:0]   token_byte;
  logic               content_valid;
  logic               token_done;
  logic [StatusW-1:0] parse_status;
  logic               last_of_run;

  modport source (output valid, output token_kind, output token_byte, output content_valid,
                  output token_done, output parse_status, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input token_byte, input content_valid,
                  input token_done, input parse_status, input last_of_run, output ready);
endinterface

FILE: hdl/htok_step.sv
// ----------------------------------------------------------------------------
// Tokenizer step logic
// Labels one byte from the current parse phase and gives up to two results.
// ----------------------------------------------------------------------------
module htok_step import htok_pkg::*; (
  input  logic [PhaseW-1:0] phase_i,
  input  logic              cr_i,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic              message_start_i,
  output htok_step_t        step_o
);

  function automatic htok_step_t crlf_token(input logic [KindW-1:0] kind,
                                            input logic [ByteW-1:0] b,
                                            input logic cr,
                                            input logic [PhaseW-1:0] ph);
    htok_step_t s;
    s.num   = NumZero;
    s.res0  = '0;
    s.res1  = '0;
    s.phase = ph;
    s.cr    = cr;
    if (cr) begin
      if (b == CharLf) begin
        s.cr    = 1'b0;
        s.phase = PhLine;
        s.num   = NumOne;
        s.res0  = mk_res(kind, CharNul, 1'b0, 1'b1, StatRunning);
      end else begin
        s.res0 = mk_res(kind, CharCr, 1'b1, 1'b0, StatRunning);
        if (b == CharCr) begin
          s.num = NumOne;
        end else begin
          s.cr   = 1'b0;
          s.num  = NumTwo;
          s.res1 = mk_res(kind, b, 1'b1, 1'b0, StatRunning);
        end
      end
    end else if (b == CharCr) begin
      s.cr = 1'b1;
    end else begin
      s.num  = NumOne;
      s.res0 = mk_res(kind, b, 1'b1, 1'b0, StatRunning);
    end
    return s;
  endfunction

  logic [PhaseW-1:0] ph;
  logic              cr;
  logic [ByteW-1:0]  b;
  htok_step_t        s;
  htok_res_t         key_res;
  logic [PhaseW-1:0] key_phase;

  assign b         = data_byte_i;
  assign key_res   = (b == CharColon) ? mk_res(KindKey, CharNul, 1'b0, 1'b1, StatRunning)
                                      : mk_res(KindKey, b, 1'b1, 1'b0, StatRunning);
  assign key_phase = (b == CharColon) ? PhSkip : PhKey;

  always_comb begin
    ph      = message_start_i ? PhMethod : phase_i;
    cr      = message_start_i ? 1'b0 : cr_i;
    s.num   = NumZero;
    s.res0  = '0;
    s.res1  = '0;
    s.phase = ph;
    s.cr    = cr;
    if (ph >= PhDone) begin
      s.num = NumZero;
    end else if (b == CharNul) begin
      s.phase = PhError;
      s.cr    = 1'b0;
      s.num   = NumOne;
      s.res0  = mk_res(phase_kind(ph), CharNul, 1'b0, 1'b0, StatError);
    end else begin
      unique case (ph)
        PhMethod, PhUrl: begin
          s.num = NumOne;
          if (b == CharSp) begin
            s.phase = ph + PhaseW'(1);
            s.res0  = mk_res(phase_kind(ph), CharNul, 1'b0, 1'b1, StatRunning);
          end else begin
            s.res0 = mk_res(phase_kind(ph), b, 1'b1, 1'b0, StatRunning);
          end
        end
        PhVersion: begin
          s = crlf_token(KindVersion, b, cr, ph);
        end
        PhLine: begin
          if (cr) begin
            s.cr = 1'b0;
            if (b == CharLf) begin
              s.phase = PhDone;
              s.num   = NumOne;
              s.res0  = mk_res(KindNone, CharNul, 1'b0, 1'b0, StatComplete);
            end else begin
              s.phase = key_phase;
              s.num   = NumTwo;
              s.res0  = mk_res(KindKey, CharCr, 1'b1, 1'b0, StatRunning);
              s.res1  = key_res;
            end
          end else if (b == CharCr) begin
            s.cr = 1'b1;
          end else begin
            s.phase = key_phase;
            s.num   = NumOne;
            s.res0  = key_res;
          end
        end
        PhKey: begin
          s.phase = key_phase;
          s.num   = NumOne;
          s.res0  = key_res;
        end
        PhSkip: begin
          if (b != CharSp) begin
            s = crlf_token(KindValue, b, cr, PhValue);
          end
        end
        PhValue: begin
          s = crlf_token(KindValue, b, cr, ph);
        end
        default: begin
          s.phase = PhError;
          s.cr    = 1'b0;
        end
      endcase
    end
    if (s.num == NumOne) begin
      s.res0.last = 1'b1;
    end
    if (s.num == NumTwo) begin
      s.res1.last = 1'b1;
    end
    step_o = s;
  end

endmodule

FILE: hdl/htok_outq.sv
// ----------------------------------------------------------------------------
// Tokenizer result queue
// Small queue that takes up to two results per cycle and gives one per cycle while its output is ready.
// ----------------------------------------------------------------------------
module htok_outq import htok_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  htok_step_t        step_i,
  output logic              room_o,
  htok_out_if.source        tok_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  htok_res_t       mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, wptr1;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NumW-1:0] num;
  logic            pop;
  htok_res_t       head;

  assign num    = push_i ? step_i.num : NumZero;
  assign pop    = tok_o.valid && tok_o.ready;
  assign wptr1  = ptr_inc(wptr_q);
  assign room_o = (cnt_q <= CntW'(Depth - 2));

  always_comb begin
    wptr_d = wptr_q;
    if (num == NumOne) begin
      wptr_d = wptr1;
    end else if (num == NumTwo) begin
      wptr_d = ptr_inc(wptr1);
    end
    rptr_d = pop ? ptr_inc(rptr_q) : rptr_q;
    cnt_d  = cnt_q + CntW'(num) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (num != NumZero) begin
      mem_q[wptr_q] <= step_i.res0;
    end
    if (num == NumTwo) begin
      mem_q[wptr1] <= step_i.res1;
    end
  end

  assign head                = mem_q[rptr_q];
  assign tok_o.valid         = (cnt_q != '0);
  assign tok_o.token_kind    = head.kind;
  assign tok_o.token_byte    = head.tbyte;
  assign tok_o.content_valid = head.cvalid;
  assign tok_o.token_done    = head.done;
  assign tok_o.parse_status  = head.status;
  assign tok_o.last_of_run   = head.last;

endmodule

FILE: hdl/http_request_header_tokenizer.sv
// ----------------------------------------------------------------------------
// HTTP request header tokenizer
// Takes request text one byte per transfer and labels each byte as method,
// URL, version, header key or header value content, or as a token end. A
// byte is taken into an input register, labeled by the parse logic and
// written as zero, one or two results into a result queue of QueueDepth
// entries. A byte can be accepted in every cycle while the queue holds at
// most QueueDepth-2 results; a byte's results show once it has passed the
// input register and the queue. The queue gives one result per cycle
// while ready; a run takes one byte per cycle, fewer with two-result bytes.
// ----------------------------------------------------------------------------
module http_request_header_tokenizer import htok_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  htok_in_if.sink    req_i,
  htok_out_if.source tok_o
);

  logic              in_v_q;
  logic [ByteW-1:0]  byte_q;
  logic              start_q;
  logic [PhaseW-1:0] phase_q;
  logic              cr_q;
  logic              room;
  logic              advance;
  logic              accept;
  htok_step_t        step;

  assign advance     = in_v_q && room;
  assign req_i.ready = !in_v_q || room;
  assign accept      = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      phase_q <= PhMethod;
      cr_q    <= 1'b0;
    end else begin
      if (accept) begin
        in_v_q <= 1'b1;
      end else if (advance) begin
        in_v_q <= 1'b0;
      end
      if (advance) begin
        phase_q <= step.phase;
        cr_q    <= step.cr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q  <= req_i.data_byte;
      start_q <= req_i.message_start;
    end
  end

  htok_step u_step (
    .phase_i         (phase_q),
    .cr_i            (cr_q),
    .data_byte_i     (byte_q),
    .message_start_i (start_q),
    .step_o          (step)
  );

  htok_outq #(
    .Depth (QueueDepth)
  ) u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (advance),
    .step_i (step),
    .room_o (room),
    .tok_o  (tok_o)
  );

endmodule

FILE: hdl/htok_checker.sv
// ----------------------------------------------------------------------------
// Tokenizer checker
// Assertions on the result channel of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "http_request_header_tokenizer_defines.svh"

module htok_checker import htok_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [KindW-1:0]   token_kind_i,
  input logic [ByteW-1:0]   token_byte_i,
  input logic               content_valid_i,
  input logic               token_done_i,
  input logic [StatusW-1:0] parse_status_i,
  input logic               last_of_run_i
);

  logic [KindW+ByteW+StatusW+2:0] payload;
  logic                           xfer;

  assign payload = {token_kind_i, token_byte_i, content_valid_i, token_done_i,
                    parse_status_i, last_of_run_i};
  assign xfer    = out_valid_i && out_ready_i;

  // A stalled result stays offered and unchanged.
  `HTOK_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(payload))

  // Completion and error are always the only result of their byte.
  `HTOK_ASSERT_SAME(a_status_last, clk_i, rst_ni, xfer && (parse_status_i != StatRunning), last_of_run_i)

  // A token end carries no content and closes the run of its byte.
  `HTOK_ASSERT_SAME(a_done_last, clk_i, rst_ni, xfer && token_done_i, last_of_run_i && !content_valid_i)

  // A result without content carries a zero byte.
  `HTOK_ASSERT_SAME(a_byte_zero, clk_i, rst_ni, xfer && !content_valid_i, token_byte_i == CharNul)

endmodule

bind http_request_header_tokenizer htok_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (tok_o.valid),
  .out_ready_i     (tok_o.ready),
  .token_kind_i    (tok_o.token_kind),
  .token_byte_i    (tok_o.token_byte),
  .content_valid_i (tok_o.content_valid),
  .token_done_i    (tok_o.token_done),
  .parse_status_i  (tok_o.parse_status),
  .last_of_run_i   (tok_o.last_of_run)
);
